[src/she_pkg.sv]
package she_pkg;

   // Configuration port
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_POINTS   = 2'd0,
      CSR_MAX_SPREAD   = 2'd1,
      CSR_MAX_JUMP     = 2'd2,
      CSR_START_HEIGHT = 2'd3
   } csr_index_type;

   // Field widths
   localparam int MIN_POINTS_W = 11;
   localparam int SPREAD_W     = 12;
   localparam int JUMP_W       = 12;
   localparam int HEIGHT_W     = 16;
   localparam int COUNT_W      = 11;
   localparam int OFFSET_W     = 24;
   localparam int STATUS_W     = 2;

   // Reset values of the configuration registers
   localparam logic [MIN_POINTS_W-1:0] MIN_POINTS_RST   = 11'd5;
   localparam logic [SPREAD_W-1:0]     MAX_SPREAD_RST   = 12'd100;
   localparam logic [JUMP_W-1:0]       MAX_JUMP_RST     = 12'd250;
   localparam logic signed [HEIGHT_W-1:0] START_HEIGHT_RST = 16'sd140;

   // Saturation limits
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7FFF;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;
   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 24'sh7FFFFF;
   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = 24'sh800000;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPTED    = 2'd0,
      STATUS_FEW_POINTS  = 2'd1,
      STATUS_WIDE_SPREAD = 2'd2
   } scan_status_type;

   // Operand pairs of the shared shift-and-add multiplier
   typedef enum logic [1:0] {
      MUL_N_SQUARES     = 2'd0,
      MUL_SUM_SUM       = 2'd1,
      MUL_N_SPREAD      = 2'd2,
      MUL_SPREAD_SPREAD = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        acc_en;
      logic        clear;
      logic        div_start;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        mean_en;
      logic        offset_en;
      logic        height_en;
      logic        load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
   } dp_status_type;

endpackage

[src/she_dp.sv]
module she_dp #(
   parameter int MAX_POINTS  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [she_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [she_pkg::CSR_DATA_W-1:0]           csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]            req_height_sample,
   input  logic                                     req_sample_valid,
   input  she_pkg::ctrl_cmd_type                    cmd,
   output she_pkg::dp_status_type                   status,
   output logic signed [she_pkg::HEIGHT_W-1:0]      rsp_height_mm,
   output logic signed [she_pkg::HEIGHT_W-1:0]      rsp_raw_mean_mm,
   output logic [she_pkg::STATUS_W-1:0]             rsp_scan_status,
   output logic                                     rsp_floor_step,
   output logic [she_pkg::COUNT_W-1:0]              rsp_valid_count
);

   localparam int CB   = $clog2(MAX_POINTS + 1);
   localparam int SUMW = SAMPLE_BITS + CB;
   localparam int SQW  = 2 * SAMPLE_BITS + CB;
   localparam int HW   = SAMPLE_BITS + CB + 4;
   localparam int PW   = 2 * HW;
   localparam int DCW  = $clog2(SUMW + 1);
   localparam int MW   = SAMPLE_BITS + 1;
   localparam int NCW  = (CB > she_pkg::MIN_POINTS_W) ? CB : she_pkg::MIN_POINTS_W;
   localparam int RMW  = (MW > she_pkg::HEIGHT_W) ? MW : she_pkg::HEIGHT_W + 1;
   localparam int HSW  = ((MW > she_pkg::OFFSET_W) ? MW : she_pkg::OFFSET_W) + 2;

   // Configuration
   logic [she_pkg::MIN_POINTS_W-1:0]   min_points_ff;
   logic [she_pkg::SPREAD_W-1:0]       max_spread_ff;
   logic [she_pkg::JUMP_W-1:0]         max_jump_ff;
   logic signed [she_pkg::HEIGHT_W-1:0] last_height_ff;
   logic signed [she_pkg::OFFSET_W-1:0] offset_ff;

   // Accumulators
   logic [CB-1:0]              count_ff;
   logic signed [SUMW-1:0]     sum_ff;
   logic [SQW-1:0]             sq_ff;
   logic [SAMPLE_BITS-1:0]     x_mag;
   logic [2*SAMPLE_BITS-1:0]   sq_term;
   logic                       sum_neg;
   logic [SUMW-1:0]            sum_mag;

   // Multiplier
   logic [PW-1:0] mul_a_ff;
   logic [HW-1:0] mul_b_ff;
   logic [PW-1:0] prod_ff;
   logic [PW-1:0] lhs_ff;
   logic          mul_busy_ff;
   logic [PW-1:0] op_a;
   logic [HW-1:0] op_b;

   // Divider
   logic            div_busy_ff;
   logic [DCW-1:0]  div_cnt_ff;
   logic [SUMW-1:0] quo_ff;
   logic [CB-1:0]   rem_ff;
   logic [CB:0]     trial;
   logic [CB:0]     trial_diff;
   logic            trial_fits;

   // Evaluation
   logic signed [MW-1:0]   mean_ff;
   logic [MW-1:0]          mean_mag;
   logic signed [MW-1:0]   mean_val;
   she_pkg::scan_status_type status_ff;
   logic                   step_ff;
   logic signed [she_pkg::HEIGHT_W-1:0] height_ff;
   logic signed [HSW-1:0]  mean_x;
   logic signed [HSW-1:0]  off_x;
   logic signed [HSW-1:0]  last_x;
   logic signed [HSW-1:0]  h_first;
   logic signed [HSW-1:0]  jump;
   logic signed [HSW-1:0]  jump_lim;
   logic                   jump_big;
   logic signed [HSW-1:0]  off_new;
   logic signed [HSW-1:0]  off_sat;
   logic signed [HSW-1:0]  h_final;
   logic signed [HSW-1:0]  h_sat;
   logic signed [RMW-1:0]  mean_r;
   logic signed [RMW-1:0]  mean_r_sat;
   logic [NCW-1:0]         count_ext;
   logic                   accepted;

   // Output word
   logic signed [she_pkg::HEIGHT_W-1:0] out_height_ff;
   logic signed [she_pkg::HEIGHT_W-1:0] out_mean_ff;
   logic [she_pkg::STATUS_W-1:0]        out_status_ff;
   logic                                out_step_ff;
   logic [she_pkg::COUNT_W-1:0]         out_count_ff;

   assign accepted = (status_ff == she_pkg::STATUS_ACCEPTED);

   // ---------------- configuration and long-lived state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_points_ff  <= she_pkg::MIN_POINTS_RST;
         max_spread_ff  <= she_pkg::MAX_SPREAD_RST;
         max_jump_ff    <= she_pkg::MAX_JUMP_RST;
         last_height_ff <= she_pkg::START_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (she_pkg::csr_index_type'(csr_index))
            she_pkg::CSR_MIN_POINTS:   min_points_ff  <= csr_wdata[she_pkg::MIN_POINTS_W-1:0];
            she_pkg::CSR_MAX_SPREAD:   max_spread_ff  <= csr_wdata[she_pkg::SPREAD_W-1:0];
            she_pkg::CSR_MAX_JUMP:     max_jump_ff    <= csr_wdata[she_pkg::JUMP_W-1:0];
            she_pkg::CSR_START_HEIGHT: last_height_ff <= csr_wdata[she_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end else if (cmd.height_en && accepted) begin
         last_height_ff <= h_sat[she_pkg::HEIGHT_W-1:0];
      end
   end

   // ---------------- accumulation ----------------
   assign x_mag   = req_height_sample[SAMPLE_BITS-1]
                    ? (~req_height_sample + 1'b1) : req_height_sample;
   assign sq_term = x_mag * x_mag;
   assign sum_neg = sum_ff[SUMW-1];
   assign sum_mag = sum_neg ? (~sum_ff + 1'b1) : sum_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else if (cmd.acc_en && req_sample_valid && (count_ff < CB'(MAX_POINTS))) begin
         count_ff <= count_ff + 1'b1;
         sum_ff   <= sum_ff + SUMW'(req_height_sample);
         sq_ff    <= sq_ff + SQW'(sq_term);
      end
   end

   // ---------------- shared shift-and-add multiplier ----------------
   always_comb begin
      case (cmd.mul_sel)
         she_pkg::MUL_N_SQUARES: begin
            op_a = PW'(sq_ff);
            op_b = HW'(count_ff);
         end
         she_pkg::MUL_SUM_SUM: begin
            op_a = PW'(sum_mag);
            op_b = HW'(sum_mag);
         end
         she_pkg::MUL_N_SPREAD: begin
            op_a = PW'(max_spread_ff);
            op_b = HW'(count_ff);
         end
         she_pkg::MUL_SPREAD_SPREAD: begin
            op_a = PW'(prod_ff[HW-1:0]);
            op_b = prod_ff[HW-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mul_busy_ff <= 1'b1;
      end else if (mul_busy_ff && (mul_b_ff == '0)) begin
         mul_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mul_a_ff <= op_a;
         mul_b_ff <= op_b;
         prod_ff  <= '0;
      end else if (mul_busy_ff && (mul_b_ff != '0)) begin
         if (mul_b_ff[0]) begin
            prod_ff <= prod_ff + mul_a_ff;
         end
         mul_a_ff <= mul_a_ff << 1;
         mul_b_ff <= mul_b_ff >> 1;
      end
   end

   // The left side of the spread test is n*sumsq, then minus sum^2 once that is done.
   always_ff @(posedge clock) begin
      if (cmd.mul_start && (cmd.mul_sel == she_pkg::MUL_SUM_SUM)) begin
         lhs_ff <= prod_ff;
      end else if (cmd.mul_start && (cmd.mul_sel == she_pkg::MUL_N_SPREAD)) begin
         lhs_ff <= lhs_ff - prod_ff;
      end
   end

   // ---------------- restoring divider, one quotient bit a cycle ----------------
   assign trial      = {rem_ff, quo_ff[SUMW-1]};
   assign trial_fits = (trial >= {1'b0, count_ff});
   assign trial_diff = trial - {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DCW'(SUMW);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (div_cnt_ff == DCW'(1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= sum_mag;
         rem_ff <= '0;
      end else if (div_busy_ff) begin
         rem_ff <= trial_fits ? trial_diff[CB-1:0] : trial[CB-1:0];
         quo_ff <= {quo_ff[SUMW-2:0], trial_fits};
      end
   end

   assign status.mul_busy = mul_busy_ff;
   assign status.div_busy = div_busy_ff;

   // ---------------- mean and status ----------------
   assign mean_mag  = {1'b0, quo_ff[SAMPLE_BITS-1:0]};
   assign mean_val  = (count_ff == '0) ? '0 : (sum_neg ? -mean_mag : mean_mag);
   assign count_ext = NCW'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.mean_en) begin
         mean_ff <= mean_val;
         if (count_ext < NCW'(min_points_ff)) begin
            status_ff <= she_pkg::STATUS_FEW_POINTS;
         end else if (lhs_ff > prod_ff) begin
            status_ff <= she_pkg::STATUS_WIDE_SPREAD;
         end else begin
            status_ff <= she_pkg::STATUS_ACCEPTED;
         end
      end
   end

   // ---------------- floor offset and height ----------------
   assign mean_x   = HSW'(mean_ff);
   assign off_x    = HSW'(offset_ff);
   assign last_x   = HSW'(last_height_ff);
   assign jump_lim = HSW'(max_jump_ff);
   assign h_first  = mean_x + off_x;
   assign jump     = last_x - h_first;
   assign jump_big = (jump > jump_lim) || (jump < -jump_lim);
   // offset + jump reduces to last height minus mean.
   assign off_new  = last_x - mean_x;
   assign off_sat  = (off_new > HSW'(she_pkg::OFFSET_MAX)) ? HSW'(she_pkg::OFFSET_MAX)
                   : (off_new < HSW'(she_pkg::OFFSET_MIN)) ? HSW'(she_pkg::OFFSET_MIN)
                   : off_new;
   assign h_final  = mean_x + off_x;
   assign h_sat    = (h_final > HSW'(she_pkg::HEIGHT_MAX)) ? HSW'(she_pkg::HEIGHT_MAX)
                   : (h_final < HSW'(she_pkg::HEIGHT_MIN)) ? HSW'(she_pkg::HEIGHT_MIN)
                   : h_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (cmd.offset_en && accepted && jump_big) begin
         offset_ff <= off_sat[she_pkg::OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.offset_en) begin
         step_ff <= accepted && jump_big;
      end
      if (cmd.height_en) begin
         height_ff <= accepted ? h_sat[she_pkg::HEIGHT_W-1:0] : last_height_ff;
      end
   end

   // ---------------- output word ----------------
   assign mean_r     = RMW'(mean_ff);
   assign mean_r_sat = (mean_r > RMW'(she_pkg::HEIGHT_MAX)) ? RMW'(she_pkg::HEIGHT_MAX)
                     : (mean_r < RMW'(she_pkg::HEIGHT_MIN)) ? RMW'(she_pkg::HEIGHT_MIN)
                     : mean_r;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_height_ff <= height_ff;
         out_mean_ff   <= mean_r_sat[she_pkg::HEIGHT_W-1:0];
         out_status_ff <= status_ff;
         out_step_ff   <= step_ff;
         out_count_ff  <= count_ext[she_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_height_mm   = out_height_ff;
   assign rsp_raw_mean_mm = out_mean_ff;
   assign rsp_scan_status = out_status_ff;
   assign rsp_floor_step  = out_step_ff;
   assign rsp_valid_count = out_count_ff;

   // No sample may be summed while the end-of-scan units still read the sums.
   a_acc_idle_units: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_en |-> (!mul_busy_ff && !div_busy_ff))
      else $error("sample accumulated while multiplier or divider busy");

endmodule

[src/she_ctrl.sv]
module she_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_scan_end,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  she_pkg::dp_status_type status,
   output she_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_ACC    = 10'b00_0000_0001,
      S_START  = 10'b00_0000_0010,
      S_M1     = 10'b00_0000_0100,
      S_M2     = 10'b00_0000_1000,
      S_M3     = 10'b00_0001_0000,
      S_M4     = 10'b00_0010_0000,
      S_MEAN   = 10'b00_0100_0000,
      S_OFFSET = 10'b00_1000_0000,
      S_HEIGHT = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_ACC: begin
            if (req_valid) begin
               cmd.acc_en = 1'b1;
               if (req_scan_end) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = she_pkg::MUL_N_SQUARES;
            state_in      = S_M1;
         end
         S_M1: begin
            if (!status.mul_busy) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = she_pkg::MUL_SUM_SUM;
               state_in      = S_M2;
            end
         end
         S_M2: begin
            if (!status.mul_busy) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = she_pkg::MUL_N_SPREAD;
               state_in      = S_M3;
            end
         end
         S_M3: begin
            if (!status.mul_busy) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = she_pkg::MUL_SPREAD_SPREAD;
               state_in      = S_M4;
            end
         end
         S_M4: begin
            if (!status.mul_busy && !status.div_busy) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            cmd.mean_en = 1'b1;
            state_in    = S_OFFSET;
         end
         S_OFFSET: begin
            cmd.offset_en = 1'b1;
            state_in      = S_HEIGHT;
         end
         S_HEIGHT: begin
            cmd.height_en = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: begin
            state_in = S_ACC;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_ACC);
   assign rsp_valid = rsp_valid_ff;

   // The last word of a scan closes the input until its result is formed.
   a_end_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_scan_end) |=> !req_ready)
      else $error("input still open after end of scan");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending result");

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

endmodule

[src/scan_height_estimator.sv]
// Height estimator for one scan of per-beam height samples.
// Input channel (req_*): one word per beam, valid/ready. Words marked
// req_scan_end close the scan. One word is taken per cycle during a scan.
// Result channel (rsp_*): one word per scan, valid/ready, held in an output
// register so the next scan can stream in while it waits.
// Configuration (csr_*): to be written only while idle, which the block
// itself does not enforce; index 3 also reloads the previous-height register.
// After the closing word the input is held off while the shared
// shift-and-add multiplier forms n*sumsq, sum^2, n*max_spread and its square,
// one bit of the multiplier a cycle, with the restoring divider for the mean
// running beside it. The result is offered once both units have finished
// and the mean, offset and height steps have run.
// If the receiver stalls, the next scan is accepted up to its closing word
// and then waits until the pending result is taken.
// Reset (synchronous) clears the sums, the floor offset and the handshakes,
// and restores the register defaults; no clearing pass is needed.
module scan_height_estimator #(
   parameter int MAX_POINTS  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [she_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [she_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_height_sample,
   input  logic                                req_sample_valid,
   input  logic                                req_scan_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [she_pkg::HEIGHT_W-1:0] rsp_height_mm,
   output logic signed [she_pkg::HEIGHT_W-1:0] rsp_raw_mean_mm,
   output logic [she_pkg::STATUS_W-1:0]        rsp_scan_status,
   output logic                                rsp_floor_step,
   output logic [she_pkg::COUNT_W-1:0]         rsp_valid_count
);

   she_pkg::ctrl_cmd_type  cmd;
   she_pkg::dp_status_type status;

   she_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_scan_end (req_scan_end),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .cmd          (cmd)
   );

   she_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_height_sample (req_height_sample),
      .req_sample_valid  (req_sample_valid),
      .cmd               (cmd),
      .status            (status),
      .rsp_height_mm     (rsp_height_mm),
      .rsp_raw_mean_mm   (rsp_raw_mean_mm),
      .rsp_scan_status   (rsp_scan_status),
      .rsp_floor_step    (rsp_floor_step),
      .rsp_valid_count   (rsp_valid_count)
   );

endmodule

[tb/scan_height_checker.sv]
`timescale 1ns / 100ps

module scan_height_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [she_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [she_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [15:0]                  req_height_sample,
   input  logic                                req_sample_valid,
   input  logic                                req_scan_end,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [she_pkg::HEIGHT_W-1:0] rsp_height_mm,
   input  logic signed [she_pkg::HEIGHT_W-1:0] rsp_raw_mean_mm,
   input  logic [she_pkg::STATUS_W-1:0]        rsp_scan_status,
   input  logic                                rsp_floor_step,
   input  logic [she_pkg::COUNT_W-1:0]         rsp_valid_count,
   output int                                  error_count,
   output int                                  pending_count
);

   localparam int MAX_BEAMS = 1024;

   typedef struct {
      logic signed [she_pkg::HEIGHT_W-1:0] height_mm;
      logic signed [she_pkg::HEIGHT_W-1:0] raw_mean_mm;
      she_pkg::scan_status_type            status;
      logic                                floor_step;
      logic [she_pkg::COUNT_W-1:0]         valid_count;
   } scan_report_type;

   scan_report_type scan_reports[$];
   scan_report_type report_due;

   longint min_points_cfg;
   longint max_spread_cfg;
   longint max_jump_cfg;
   longint beam_count;
   longint beam_sum;
   longint square_sum;
   longint prev_height;
   longint floor_offset;
   int     mismatches = 0;

   assign error_count = mismatches;

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Closes the running scan: works out its report, updates the height
   // tracking and clears the sums for the next scan.
   function automatic scan_report_type close_scan();
      scan_report_type r;
      longint mean;
      longint level;
      longint jump;
      longint spread_lhs;
      longint spread_rhs;
      mean = 0;
      if (beam_count > 0) begin
         mean = beam_sum / beam_count;
      end
      r.height_mm   = prev_height[she_pkg::HEIGHT_W-1:0];
      r.raw_mean_mm = mean[she_pkg::HEIGHT_W-1:0];
      r.status      = she_pkg::STATUS_ACCEPTED;
      r.floor_step  = 1'b0;
      r.valid_count = beam_count[she_pkg::COUNT_W-1:0];
      if (beam_count < min_points_cfg) begin
         r.status = she_pkg::STATUS_FEW_POINTS;
      end else begin
         // Variance test scaled by n^2 so that no root is needed.
         spread_lhs = beam_count * square_sum - beam_sum * beam_sum;
         spread_rhs = (beam_count * max_spread_cfg) * (beam_count * max_spread_cfg);
         if (spread_lhs > spread_rhs) begin
            r.status = she_pkg::STATUS_WIDE_SPREAD;
         end else begin
            level = mean + floor_offset;
            jump  = prev_height - level;
            if ((jump < 0 ? -jump : jump) > max_jump_cfg) begin
               floor_offset = saturate(floor_offset + jump, she_pkg::OFFSET_MIN,
                                       she_pkg::OFFSET_MAX);
               r.floor_step = 1'b1;
               level = mean + floor_offset;
            end
            prev_height = saturate(level, she_pkg::HEIGHT_MIN, she_pkg::HEIGHT_MAX);
            r.height_mm = prev_height[she_pkg::HEIGHT_W-1:0];
         end
      end
      beam_count = 0;
      beam_sum   = 0;
      square_sum = 0;
      return r;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         min_points_cfg = she_pkg::MIN_POINTS_RST;
         max_spread_cfg = she_pkg::MAX_SPREAD_RST;
         max_jump_cfg   = she_pkg::MAX_JUMP_RST;
         prev_height    = she_pkg::START_HEIGHT_RST;
         floor_offset   = 0;
         beam_count     = 0;
         beam_sum       = 0;
         square_sum     = 0;
         scan_reports.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (scan_reports.size() == 0) begin
               mismatches++;
               $display("%0t: result word with no scan pending, expected none, got %0d",
                        $time, rsp_height_mm);
            end else begin
               report_due = scan_reports.pop_front();
               check_field("height_mm", report_due.height_mm, rsp_height_mm);
               check_field("raw_mean_mm", report_due.raw_mean_mm, rsp_raw_mean_mm);
               check_field("scan_status", report_due.status, rsp_scan_status);
               check_field("floor_step", report_due.floor_step, rsp_floor_step);
               check_field("valid_count", report_due.valid_count, rsp_valid_count);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               she_pkg::CSR_MIN_POINTS:
                  min_points_cfg = csr_wdata[she_pkg::MIN_POINTS_W-1:0];
               she_pkg::CSR_MAX_SPREAD:
                  max_spread_cfg = csr_wdata[she_pkg::SPREAD_W-1:0];
               she_pkg::CSR_MAX_JUMP:
                  max_jump_cfg = csr_wdata[she_pkg::JUMP_W-1:0];
               she_pkg::CSR_START_HEIGHT:
                  prev_height = longint'(signed'(csr_wdata[she_pkg::HEIGHT_W-1:0]));
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            // Valid beams beyond the point limit of a scan are dropped.
            if (req_sample_valid && beam_count < MAX_BEAMS) begin
               beam_count++;
               beam_sum   += req_height_sample;
               square_sum += longint'(req_height_sample) * req_height_sample;
            end
            if (req_scan_end) begin
               scan_reports.insert(scan_reports.size(), close_scan());
            end
         end
         pending_count <= scan_reports.size();
      end
   end

endmodule

[tb/tb_scan_height_estimator.sv]
`timescale 1ns / 100ps

module tb_scan_height_estimator;

   localparam int SAMPLE_W     = 16;
   localparam int PHASE_BEAMS  = 110;
   localparam int SETTLE       = 100;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_wr_en = 1'b0;
   logic [she_pkg::CSR_IDX_W-1:0]        csr_index = she_pkg::CSR_MIN_POINTS;
   logic [she_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [SAMPLE_W-1:0]           req_height_sample = '0;
   logic                                 req_sample_valid = 1'b0;
   logic                                 req_scan_end = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [she_pkg::HEIGHT_W-1:0]  rsp_height_mm;
   logic signed [she_pkg::HEIGHT_W-1:0]  rsp_raw_mean_mm;
   logic [she_pkg::STATUS_W-1:0]         rsp_scan_status;
   logic                                 rsp_floor_step;
   logic [she_pkg::COUNT_W-1:0]          rsp_valid_count;
   int                                   error_count;
   int                                   pending_count;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic recv_hold = 1'b0;
   int   beams_sent = 0;
   int   spread_setting = 100;
   int   level_mm = 140;

   scan_height_estimator i_dut (.*);

   scan_height_checker i_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int clip_mm(input int v);
      return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
   endfunction

   // Valid is lowered only in an idle cycle or after the last word of a burst.
   task automatic send_word(input logic signed [SAMPLE_W-1:0] sample, input logic counted,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_height_sample <= sample;
      req_sample_valid  <= counted;
      req_scan_end      <= last;
      do @(posedge clock); while (!req_ready);
      beams_sent++;
   endtask

   task automatic send_scan(input int beams, input int center, input int noise,
                            input int valid_pct, input bit wild);
      int v;
      for (int i = 0; i < beams; i++) begin
         if (wild) begin
            v = int'($urandom_range(65535)) - 32768;
         end else begin
            v = clip_mm(center + int'($urandom_range(2 * noise)) - noise);
         end
         send_word(v[SAMPLE_W-1:0], $urandom_range(99) < valid_pct, i == beams - 1);
      end
   endtask

   task automatic random_scan();
      int kind;
      int beams;
      int noise;
      kind  = $urandom_range(9);
      beams = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 20);
      if (kind == 0) begin
         send_scan(beams, 0, 0, $urandom_range(100), 1'b1);
      end else if (kind == 1) begin
         send_scan(beams, level_mm, spread_setting, 25, 1'b0);
      end else begin
         // Mostly a slow drift of the floor, now and then a step or a new level.
         case ($urandom_range(9))
            0:       level_mm = int'($urandom_range(65535)) - 32768;
            1, 2:    level_mm = clip_mm(level_mm + int'($urandom_range(8000)) - 4000);
            default: level_mm = clip_mm(level_mm + int'($urandom_range(600)) - 300);
         endcase
         noise = $urandom_range(0, spread_setting + spread_setting / 2 + 2);
         send_scan(beams, level_mm, noise, 92, 1'b0);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Bits above each register's width carry random junk.
   task automatic write_settings(input int min_pts, input int spread, input int jump,
                                 input bit with_seed, input int seed);
      csr_wr_en <= 1'b1;
      csr_index <= she_pkg::CSR_MIN_POINTS;
      csr_wdata <= 16'(min_pts) | (16'($urandom) << she_pkg::MIN_POINTS_W);
      @(posedge clock);
      csr_index <= she_pkg::CSR_MAX_SPREAD;
      csr_wdata <= 16'(spread) | (16'($urandom) << she_pkg::SPREAD_W);
      @(posedge clock);
      csr_index <= she_pkg::CSR_MAX_JUMP;
      csr_wdata <= 16'(jump) | (16'($urandom) << she_pkg::JUMP_W);
      @(posedge clock);
      if (with_seed) begin
         csr_index <= she_pkg::CSR_START_HEIGHT;
         csr_wdata <= 16'(seed);
         @(posedge clock);
         level_mm = seed;
      end
      csr_wr_en <= 1'b0;
      spread_setting = spread;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults from reset: an empty scan, a flat scan, extremes of the sample.
      send_word(16'sd0, 1'b0, 1'b1);
      send_scan(5, 140, 0, 100, 1'b0);
      repeat (3) send_word(16'sh7FFF, 1'b1, 1'b0);
      repeat (2) send_word(16'sh8000, 1'b1, 1'b0);
      send_word(16'sh8000, 1'b1, 1'b1);
      repeat (4) send_word(16'sh7FFF, 1'b1, 1'b0);
      send_word(16'sh1234, 1'b0, 1'b0);
      send_word(16'sh7FFF, 1'b1, 1'b1);
      // Mean of -9 over five beams truncates toward zero.
      send_word(-16'sd1, 1'b1, 1'b0);
      repeat (3) send_word(-16'sd2, 1'b1, 1'b0);
      send_word(-16'sd2, 1'b1, 1'b1);
      wait_drained();

      // Lowest limits: an empty scan passes, any spread at all fails.
      write_settings(0, 0, 0, 1'b1, -32768);
      send_word(16'sd0, 1'b0, 1'b1);
      send_scan(4, 77, 0, 100, 1'b0);
      send_word(16'sd77, 1'b1, 1'b0);
      send_word(16'sd78, 1'b1, 1'b1);
      wait_drained();

      // More valid beams than the point limit in one scan.
      write_settings(1024, 4095, 4095, 1'b1, 30000);
      send_scan(1030, 100, 50, 100, 1'b0);
      wait_drained();

      // A large absorbed offset pushes the next height past both rails.
      write_settings(1, 4095, 4095, 1'b1, 30000);
      send_scan(5, -30000, 0, 100, 1'b0);
      send_scan(5, -26000, 0, 100, 1'b0);
      wait_drained();
      write_settings(1, 4095, 4095, 1'b1, -30000);
      send_scan(5, 30000, 0, 100, 1'b0);
      send_scan(5, 26000, 0, 100, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_settings($urandom_range(2, 10), $urandom_range(20, 300),
                              $urandom_range(50, 800), 1'b1, 140);
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               write_settings(0, 0, 0, 1'b0, 0);
               send_idle_pct = 63;
               recv_stall_pct <= 0;
            end
            2: begin
               write_settings($urandom_range(0, 12), $urandom_range(0, 400),
                              $urandom_range(0, 1000), 1'b1,
                              int'($urandom_range(65535)) - 32768);
               send_idle_pct = 0;
               recv_stall_pct <= 63;
            end
            3: begin
               write_settings($urandom_range(0, 12), $urandom_range(0, 400),
                              $urandom_range(0, 1000), 1'b0, 0);
               send_idle_pct = 19;
               recv_stall_pct <= 19;
            end
            4: begin
               write_settings($urandom_range(0, 12), $urandom_range(0, 400),
                              $urandom_range(0, 1000), 1'b1,
                              int'($urandom_range(65535)) - 32768);
               send_idle_pct = 0;
               recv_stall_pct <= 0;
               // Receiver holds off while words keep coming, so the block backs up.
               recv_hold <= 1'b1;
               fork
                  begin
                     repeat (1500) @(posedge clock);
                     recv_hold <= 1'b0;
                  end
               join_none
            end
            default: begin
               write_settings(12, 4095, 4095, 1'b0, 0);
               send_idle_pct = 19;
               recv_stall_pct <= 19;
            end
         endcase
         beams_sent = 0;
         while (beams_sent < PHASE_BEAMS) random_scan();
      end

      wait_drained();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
